### rtl/core/ccr_pkg.sv
// ============================================================================
// ccr_pkg
// shared types and constants of the calibration command responder
// ============================================================================
`default_nettype none
package ccr_pkg;

   localparam logic [2:0] OP_CONNECT  = 3'd0;
   localparam logic [2:0] OP_STATUS   = 3'd1;
   localparam logic [2:0] OP_DOWNLOAD = 3'd2;
   localparam logic [2:0] OP_UPLOAD   = 3'd3;
   localparam logic [2:0] OP_UNKNOWN  = 3'd4;
   localparam logic [2:0] OP_LOAD     = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOT_CONN = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_INVALID  = 3'd4;
   localparam logic [2:0] ST_FRAME    = 3'd5;

   localparam logic [2:0] EK_NONE     = 3'd0;
   localparam logic [2:0] EK_INVALID  = 3'd1;
   localparam logic [2:0] EK_NOT_CONN = 3'd2;
   localparam logic [2:0] EK_RANGE    = 3'd3;
   localparam logic [2:0] EK_UNKNOWN  = 3'd4;

   localparam logic [7:0] LEN_DOWNLOAD = 8'd7;
   localparam logic [7:0] LEN_UPLOAD   = 8'd3;
   localparam logic [7:0] CAP_STATUS   = 8'd4;
   localparam logic [7:0] CAP_UPLOAD   = 8'd5;

   localparam logic [2:0] CSR_ENTRY_COUNT = 3'd0;

   // classified command handed from front to back
   localparam logic [2:0] CL_REPLY    = 3'd0; // immediate reply, fields precomputed
   localparam logic [2:0] CL_LOAD     = 3'd1;
   localparam logic [2:0] CL_DOWNLOAD = 3'd2;
   localparam logic [2:0] CL_UPLOAD   = 3'd3;
   localparam logic [2:0] CL_STATUS   = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  capacity;
      logic [15:0] address;
      logic [31:0] value_bits;
      logic [2:0]  entry_index;
      logic [31:0] entry_minimum;
      logic [31:0] entry_maximum;
      logic        index_ok;
      logic        set_connected;
      logic [2:0]  status;
      logic [2:0]  length;
      logic        is_error;
      logic [2:0]  error_kind;
   } cmd_type;

   // ieee a < b, false when either is nan
   function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic both_zero;
      logic res;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (a_nan || b_nan || both_zero) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (a[31] == 1'b0) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction

   // reply with kind; kind none is a one-byte positive reply
   function automatic logic [9:0] make_reply(input logic [7:0] cap, input logic [2:0] kind);
      logic [9:0] r;
      logic [7:0] need;
      logic [2:0] st;
      need = (kind == EK_NONE) ? 8'd1 : 8'd2;
      unique case (kind)
         EK_NONE:     st = ST_OK;
         EK_NOT_CONN: st = ST_NOT_CONN;
         EK_RANGE:    st = ST_RANGE;
         EK_UNKNOWN:  st = ST_UNKNOWN;
         default:     st = ST_INVALID;
      endcase
      if (cap < need) begin
         r = {ST_FRAME, 3'd0, 1'b0, EK_NONE};
      end else begin
         r = {st, need[2:0], kind != EK_NONE, kind};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/ccr_front.sv
// ============================================================================
// ccr_front
// accepts requests, checks lengths and connection, tracks link state
// ============================================================================
`default_nettype none
module ccr_front
   import ccr_pkg::*;
#(
   parameter int TABLE_ENTRIES   = 8,
   parameter int MAX_FRAME_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_frame_length,
   input  wire logic [7:0]  req_response_capacity,
   input  wire logic [15:0] req_address,
   input  wire logic [31:0] req_value_bits,
   input  wire logic [2:0]  req_entry_index,
   input  wire logic [31:0] req_entry_minimum,
   input  wire logic [31:0] req_entry_maximum,
   output logic             cmd_valid,
   input  wire logic        cmd_full,
   output cmd_type          cmd
);

   logic connected_ff;
   logic connected_in;
   logic [9:0] rep;
   logic [7:0] need_len;
   logic accept;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;
   assign cmd_valid = accept;

   always_comb begin
      cmd = '0;
      cmd.capacity      = req_response_capacity;
      cmd.address       = req_address;
      cmd.value_bits    = req_value_bits;
      cmd.entry_index   = req_entry_index;
      cmd.entry_minimum = req_entry_minimum;
      cmd.entry_maximum = req_entry_maximum;
      cmd.index_ok      = 32'(req_entry_index) < TABLE_ENTRIES;
      cmd.kind          = CL_REPLY;
      rep = '0;
      unique case (req_opcode)
         OP_DOWNLOAD: need_len = LEN_DOWNLOAD;
         OP_UPLOAD:   need_len = LEN_UPLOAD;
         default:     need_len = 8'd1;
      endcase
      priority if (req_opcode == OP_LOAD) begin
         cmd.kind = CL_LOAD;
      end else if (req_frame_length == 8'd0 || 32'(req_frame_length) > MAX_FRAME_BYTES) begin
         rep = {ST_INVALID, 3'd0, 1'b0, EK_NONE};
      end else if (req_opcode > OP_UPLOAD) begin
         rep = make_reply(req_response_capacity, EK_UNKNOWN);
      end else if (req_frame_length != need_len) begin
         rep = make_reply(req_response_capacity, EK_INVALID);
      end else if (req_opcode == OP_CONNECT) begin
         rep = make_reply(req_response_capacity, EK_NONE);
         cmd.set_connected = 1'b1;
      end else if (!connected_ff) begin
         if (req_response_capacity < 8'd2) begin
            rep = {ST_NOT_CONN, 3'd0, 1'b0, EK_NONE};
         end else begin
            rep = make_reply(req_response_capacity, EK_NOT_CONN);
         end
      end else if (req_opcode == OP_STATUS) begin
         cmd.kind = CL_STATUS;
      end else if (req_opcode == OP_DOWNLOAD) begin
         cmd.kind = CL_DOWNLOAD;
      end else begin
         cmd.kind = CL_UPLOAD;
      end
      {cmd.status, cmd.length, cmd.is_error, cmd.error_kind} = rep;
   end

   assign connected_in = connected_ff || (accept && cmd.set_connected);

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
      end else begin
         connected_ff <= connected_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ccr_queue.sv
// ============================================================================
// ccr_queue
// two-entry queue of classified commands between front and back
// ============================================================================
`default_nettype none
module ccr_queue
   import ccr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_data,
   output logic         full,
   output logic         not_empty,
   input  wire logic    pop,
   output cmd_type      head
);

   cmd_type    mem_ff [2];
   logic       wr_ff;
   logic       wr_in;
   logic       rd_ff;
   logic       rd_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_pop;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ff];
   assign wr_in     = wr_ff ^ push;
   assign rd_in     = rd_ff ^ do_pop;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(do_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");

endmodule
`default_nettype wire

### rtl/core/ccr_back.sv
// ============================================================================
// ccr_back
// table search and update, one slot per cycle, with registered result
// ============================================================================
`default_nettype none
module ccr_back
   import ccr_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [3:0]  entry_count,
   input  wire logic        cmd_present,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_status,
   output logic [2:0]       rsp_response_length,
   output logic             rsp_response_is_error,
   output logic [2:0]       rsp_error_kind,
   output logic [31:0]      rsp_payload
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;

   logic [15:0] addr_ff [TABLE_ENTRIES];
   logic [31:0] min_ff  [TABLE_ENTRIES];
   logic [31:0] max_ff  [TABLE_ENTRIES];
   logic [31:0] val_ff  [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] written_ff;
   logic [TABLE_ENTRIES-1:0] written_in;
   logic        dirty_ff;
   logic        dirty_in;
   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   logic [CW-1:0] pos_ff;
   logic [CW-1:0] pos_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [2:0]  st_ff, st_in;
   logic [2:0]  len_ff, len_in;
   logic        err_ff, err_in;
   logic [2:0]  ek_ff, ek_in;
   logic [31:0] pay_ff, pay_in;
   logic [CW-1:0] used;
   logic        out_free;
   logic        finish;
   logic        wr_slot;
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] pidx;
   logic        hit;
   logic        done_scan;
   logic [9:0]  rep;
   logic        in_range;
   logic        write_val;

   assign used = (32'(entry_count) > TABLE_ENTRIES) ? CW'(TABLE_ENTRIES) : CW'(entry_count);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign pidx = pos_ff[IW-1:0];

   assign rsp_valid             = out_valid_ff;
   assign rsp_result_status     = st_ff;
   assign rsp_response_length   = len_ff;
   assign rsp_response_is_error = err_ff;
   assign rsp_error_kind        = ek_ff;
   assign rsp_payload           = pay_ff;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      finish     = 1'b0;
      wr_slot    = 1'b0;
      write_val  = 1'b0;
      wr_idx     = IW'(cmd.entry_index);
      written_in = written_ff;
      dirty_in   = dirty_ff;
      st_in      = cmd.status;
      len_in     = cmd.length;
      err_in     = cmd.is_error;
      ek_in      = cmd.error_kind;
      pay_in     = 32'd0;
      rep        = '0;
      hit        = 1'b0;
      in_range   = 1'b0;
      done_scan  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_present && out_free) begin
               unique case (cmd.kind)
                  CL_REPLY: finish = 1'b1;
                  CL_STATUS: begin
                     finish = 1'b1;
                     if (cmd.capacity < CAP_STATUS) begin
                        {st_in, len_in, err_in, ek_in} = {ST_FRAME, 3'd0, 1'b0, EK_NONE};
                     end else begin
                        {st_in, len_in, err_in, ek_in} = {ST_OK, 3'd4, 1'b0, EK_NONE};
                        pay_in = {8'd0, 8'(used), 7'd0, dirty_ff, 8'd1};
                     end
                  end
                  default: begin
                     state_in = S_SCAN;
                     pos_in   = '0;
                  end
               endcase
            end
         end
         default: begin
            if (cmd.kind == CL_LOAD) begin
               done_scan = 32'(pos_ff) >= TABLE_ENTRIES;
               if (!done_scan) begin
                  hit = (pidx != IW'(cmd.entry_index)) && written_ff[pidx]
                        && addr_ff[pidx] == cmd.address;
               end
               if (!cmd.index_ok || fp_less(cmd.entry_maximum, cmd.entry_minimum) || hit) begin
                  finish = 1'b1;
                  {st_in, len_in, err_in, ek_in} = {ST_INVALID, 3'd0, 1'b0, EK_NONE};
               end else if (done_scan) begin
                  finish  = 1'b1;
                  wr_slot = 1'b1;
                  written_in[wr_idx] = 1'b1;
                  {st_in, len_in, err_in, ek_in} = {ST_OK, 3'd0, 1'b0, EK_NONE};
               end
            end else begin
               done_scan = pos_ff >= used;
               if (!done_scan) begin
                  hit = addr_ff[pidx] == cmd.address;
               end
               if (done_scan) begin
                  finish = 1'b1;
                  rep = make_reply(cmd.capacity, EK_RANGE);
                  {st_in, len_in, err_in, ek_in} = rep;
               end else if (hit) begin
                  finish = 1'b1;
                  if (cmd.kind == CL_DOWNLOAD) begin
                     in_range = !fp_less(cmd.value_bits, min_ff[pidx])
                                && !fp_less(max_ff[pidx], cmd.value_bits);
                     if (in_range) begin
                        write_val = 1'b1;
                        dirty_in  = 1'b1;
                        rep = make_reply(cmd.capacity, EK_NONE);
                     end else begin
                        rep = make_reply(cmd.capacity, EK_RANGE);
                     end
                     {st_in, len_in, err_in, ek_in} = rep;
                  end else if (cmd.capacity < CAP_UPLOAD) begin
                     rep = make_reply(cmd.capacity, EK_RANGE);
                     {st_in, len_in, err_in, ek_in} = rep;
                  end else begin
                     {st_in, len_in, err_in, ek_in} = {ST_OK, 3'd5, 1'b0, EK_NONE};
                     pay_in = val_ff[pidx];
                  end
               end
            end
            if (finish) begin
               state_in = S_IDLE;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
      endcase
      cmd_pop      = finish;
      out_valid_in = finish || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (wr_slot) begin
         addr_ff[wr_idx] <= cmd.address;
         min_ff[wr_idx]  <= cmd.entry_minimum;
         max_ff[wr_idx]  <= cmd.entry_maximum;
         val_ff[wr_idx]  <= cmd.value_bits;
      end else if (write_val) begin
         val_ff[pidx] <= cmd.value_bits;
      end
      if (finish) begin
         st_ff  <= st_in;
         len_ff <= len_in;
         err_ff <= err_in;
         ek_ff  <= ek_in;
         pay_ff <= pay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         written_ff   <= '0;
         dirty_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         written_ff   <= written_in;
         dirty_ff     <= dirty_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> out_valid_ff && $stable(pay_ff) && $stable(st_ff))
      else $error("stalled response changed");
   assert property (@(posedge clock) disable iff (reset) finish |-> out_free)
      else $error("response overwritten");
   assert property (@(posedge clock) disable iff (reset) !(wr_slot && write_val))
      else $error("two table writes in one cycle");
   assert property (@(posedge clock) disable iff (reset) dirty_ff |=> dirty_ff)
      else $error("dirty flag cleared");

endmodule
`default_nettype wire

### rtl/core/calibration_command_responder.sv
// ============================================================================
// calibration_command_responder
// answers calibration command requests against a parameter table
// ============================================================================
// direct replies skip the scan; table work scans one slot a cycle, up to the
//   entries searched (TABLE_ENTRIES for a load)
// requests are taken while the back end works, until the two-entry queue is full
// reset: synchronous; link, dirty flag and slot valid bits clear, entry_count 1
// ============================================================================
`default_nettype none
module calibration_command_responder
   import ccr_pkg::*;
#(
   parameter int TABLE_ENTRIES   = 8,
   parameter int MAX_FRAME_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_frame_length,
   input  wire logic [7:0]  req_response_capacity,
   input  wire logic [15:0] req_address,
   input  wire logic [31:0] req_value_bits,
   input  wire logic [2:0]  req_entry_index,
   input  wire logic [31:0] req_entry_minimum,
   input  wire logic [31:0] req_entry_maximum,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_result_status,
   output logic [2:0]       rsp_response_length,
   output logic             rsp_response_is_error,
   output logic [2:0]       rsp_error_kind,
   output logic [31:0]      rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [3:0] count_ff;
   logic [3:0] count_in;
   logic       push;
   logic       full;
   logic       present;
   logic       pop;
   cmd_type    front_cmd;
   cmd_type    head;

   assign csr_pready = 1'b1;
   assign count_in = (csr_psel && csr_penable && csr_pwrite
                      && csr_paddr[2] == CSR_ENTRY_COUNT[0] && csr_paddr[1:0] == 2'd0)
                     ? csr_pwdata[3:0] : count_ff;
   assign csr_prdata = (csr_paddr == {CSR_ENTRY_COUNT[0], 2'd0}) ? {28'd0, count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd1;
      end else begin
         count_ff <= count_in;
      end
   end

   ccr_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_frame_length,
      .req_response_capacity, .req_address, .req_value_bits, .req_entry_index,
      .req_entry_minimum, .req_entry_maximum,
      .cmd_valid(push), .cmd_full(full), .cmd(front_cmd)
   );

   ccr_queue u_queue (
      .clock, .reset, .push, .push_data(front_cmd), .full, .not_empty(present),
      .pop, .head
   );

   ccr_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .entry_count(count_ff), .cmd_present(present), .cmd(head),
      .cmd_pop(pop), .rsp_valid, .rsp_stall, .rsp_result_status, .rsp_response_length,
      .rsp_response_is_error, .rsp_error_kind, .rsp_payload
   );

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// calibration_command_responder testbench
// drives calibration requests with bursty timing against a random stalling
// receiver, predicts each reply from a local copy of the parameter table and
// connection state, and checks every reply field in order; entry_count is
// rewritten between phases while the block is idle
// ============================================================================
`default_nettype none
module testbench;
   import ccr_pkg::*;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  frame_length;
      logic [7:0]  capacity;
      logic [15:0] address;
      logic [31:0] value_bits;
      logic [2:0]  entry_index;
      logic [31:0] entry_minimum;
      logic [31:0] entry_maximum;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  length;
      logic        is_error;
      logic [2:0]  error_kind;
      logic [31:0] payload;
   } reply_type;

   class responder_book;
      reply_type   pending_replies[$];
      logic [15:0] slot_address[8];
      logic [31:0] slot_minimum[8];
      logic [31:0] slot_maximum[8];
      logic [31:0] slot_value[8];
      bit          slot_written[8];
      bit          connected;
      bit          dirty;
      logic [3:0]  entry_count;
      int          failures;

      function new();
         connected = 0;
         dirty = 0;
         entry_count = 4'd1;
         failures = 0;
         foreach (slot_written[i]) slot_written[i] = 0;
      endfunction

      function bit is_nan(logic [31:0] b);
         return b[30:23] == 8'hff && b[22:0] != 23'd0;
      endfunction

      // ieee a < b via a monotonic integer key
      function bit fp_lt(logic [31:0] a, logic [31:0] b);
         logic [31:0] ka;
         logic [31:0] kb;
         if (is_nan(a) || is_nan(b)) return 0;
         if (a[30:0] == 31'd0) a = 32'd0;
         if (b[30:0] == 31'd0) b = 32'd0;
         ka = a[31] ? ~a : (a | 32'h8000_0000);
         kb = b[31] ? ~b : (b | 32'h8000_0000);
         return ka < kb;
      endfunction

      function int searched();
         return entry_count > 4'd8 ? 8 : int'(entry_count);
      endfunction

      function int find_slot(logic [15:0] addr);
         for (int i = 0; i < searched(); i++) begin
            if (slot_address[i] == addr) return i;
         end
         return -1;
      endfunction

      function reply_type short_reply(logic [7:0] cap, logic [2:0] kind);
         reply_type r;
         r = '0;
         if (cap < (kind == EK_NONE ? 8'd1 : 8'd2)) begin
            r.status = ST_FRAME;
            return r;
         end
         case (kind)
            EK_NONE:     r.status = ST_OK;
            EK_NOT_CONN: r.status = ST_NOT_CONN;
            EK_RANGE:    r.status = ST_RANGE;
            EK_UNKNOWN:  r.status = ST_UNKNOWN;
            default:     r.status = ST_INVALID;
         endcase
         r.length = kind == EK_NONE ? 3'd1 : 3'd2;
         r.is_error = kind != EK_NONE;
         r.error_kind = kind;
         return r;
      endfunction

      function void predict_request(request_type q);
         reply_type r;
         int s;
         logic [7:0] need_len;
         r = '0;
         if (q.opcode == OP_LOAD) begin
            r.status = ST_INVALID;
            if (!fp_lt(q.entry_maximum, q.entry_minimum)) begin
               s = 1;
               for (int j = 0; j < 8; j++) begin
                  if (j != q.entry_index && slot_written[j] && slot_address[j] == q.address)
                     s = 0;
               end
               if (s) begin
                  slot_address[q.entry_index] = q.address;
                  slot_minimum[q.entry_index] = q.entry_minimum;
                  slot_maximum[q.entry_index] = q.entry_maximum;
                  slot_value[q.entry_index] = q.value_bits;
                  slot_written[q.entry_index] = 1;
                  r.status = ST_OK;
               end
            end
         end else if (q.frame_length == 8'd0 || q.frame_length > 8'd8) begin
            r.status = ST_INVALID;
         end else if (q.opcode > OP_UPLOAD) begin
            r = short_reply(q.capacity, EK_UNKNOWN);
         end else begin
            need_len = q.opcode == OP_DOWNLOAD ? LEN_DOWNLOAD :
                       q.opcode == OP_UPLOAD ? LEN_UPLOAD : 8'd1;
            if (q.frame_length != need_len) begin
               r = short_reply(q.capacity, EK_INVALID);
            end else if (q.opcode == OP_CONNECT) begin
               connected = 1;
               r = short_reply(q.capacity, EK_NONE);
            end else if (!connected) begin
               if (q.capacity < 8'd2) r.status = ST_NOT_CONN;
               else r = short_reply(q.capacity, EK_NOT_CONN);
            end else if (q.opcode == OP_STATUS) begin
               if (q.capacity < CAP_STATUS) begin
                  r.status = ST_FRAME;
               end else begin
                  r.length = 3'd4;
                  r.payload = {8'd0, 8'(searched()), 7'd0, dirty, 7'd0, connected};
               end
            end else begin
               s = find_slot(q.address);
               if (q.opcode == OP_DOWNLOAD) begin
                  if (s < 0 || fp_lt(q.value_bits, slot_minimum[s]) ||
                      fp_lt(slot_maximum[s], q.value_bits)) begin
                     r = short_reply(q.capacity, EK_RANGE);
                  end else begin
                     slot_value[s] = q.value_bits;
                     dirty = 1;
                     r = short_reply(q.capacity, EK_NONE);
                  end
               end else if (s < 0 || q.capacity < CAP_UPLOAD) begin
                  r = short_reply(q.capacity, EK_RANGE);
               end else begin
                  r.length = 3'd5;
                  r.payload = slot_value[s];
               end
            end
         end
         pending_replies.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type e;
         if (pending_replies.size() == 0) begin
            $error("reply with none expected");
            failures++;
            return;
         end
         e = pending_replies.pop_front();
         if (got.status !== e.status) begin
            $error("result_status exp %0d got %0d", e.status, got.status);
            failures++;
         end
         if (got.length !== e.length) begin
            $error("response_length exp %0d got %0d", e.length, got.length);
            failures++;
         end
         if (got.is_error !== e.is_error) begin
            $error("response_is_error exp %0d got %0d", e.is_error, got.is_error);
            failures++;
         end
         if (got.error_kind !== e.error_kind) begin
            $error("error_kind exp %0d got %0d", e.error_kind, got.error_kind);
            failures++;
         end
         if (got.payload !== e.payload) begin
            $error("payload exp %h got %h", e.payload, got.payload);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_frame_length = '0;
   logic [7:0]  req_response_capacity = '0;
   logic [15:0] req_address = '0;
   logic [31:0] req_value_bits = '0;
   logic [2:0]  req_entry_index = '0;
   logic [31:0] req_entry_minimum = '0;
   logic [31:0] req_entry_maximum = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_result_status;
   logic [2:0]  rsp_response_length;
   logic        rsp_response_is_error;
   logic [2:0]  rsp_error_kind;
   logic [31:0] rsp_payload;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   responder_book book = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_timer = 0;

   calibration_command_responder u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_timer = $urandom_range(20, 120);
      end
      stall_timer--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_reply({rsp_result_status, rsp_response_length, rsp_response_is_error,
                           rsp_error_kind, rsp_payload});
   end

   task automatic send_request(request_type q);
      if (burst_left == 0) begin
         int gap;
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= q.opcode;
      req_frame_length <= q.frame_length;
      req_response_capacity <= q.capacity;
      req_address <= q.address;
      req_value_bits <= q.value_bits;
      req_entry_index <= q.entry_index;
      req_entry_minimum <= q.entry_minimum;
      req_entry_maximum <= q.entry_maximum;
      do @(posedge clock); while (req_stall);
      book.predict_request(q);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (book.pending_replies.size() != 0) @(posedge clock);
      repeat (14) @(posedge clock);
   endtask

   task automatic write_entry_count(logic [3:0] count);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(CSR_ENTRY_COUNT << 2);
      csr_pwdata <= {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, count};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.entry_count = count;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_float();
      case ($urandom_range(0, 11))
         0: return 32'h7fc0_0000 | $urandom_range(0, 32'h3f_ffff);
         1: return 32'h0000_0000;
         2: return 32'h8000_0000;
         3: return 32'h7f80_0000;
         4: return 32'hff80_0000;
         5: return 32'h3f80_0000;
         6: return 32'hbf80_0000;
         7: return 32'h42c8_0000;
         8: return 32'hc2c8_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type make_request(logic [2:0] op, logic [7:0] len,
                                                 logic [7:0] cap, logic [15:0] addr,
                                                 logic [31:0] value);
      request_type q;
      q = '0;
      q.opcode = op;
      q.frame_length = len;
      q.capacity = cap;
      q.address = addr;
      q.value_bits = value;
      return q;
   endfunction

   function automatic request_type make_load(logic [2:0] idx, logic [15:0] addr,
                                             logic [31:0] lo, logic [31:0] hi, logic [31:0] v);
      request_type q;
      q = make_request(OP_LOAD, 8'($urandom), 8'($urandom), addr, v);
      q.entry_index = idx;
      q.entry_minimum = lo;
      q.entry_maximum = hi;
      return q;
   endfunction

   function automatic request_type random_request();
      request_type q;
      int s;
      logic [2:0] ops[7] = '{OP_CONNECT, OP_STATUS, OP_DOWNLOAD, OP_UPLOAD,
                             OP_DOWNLOAD, OP_UPLOAD, OP_LOAD};
      logic [15:0] pool[6] = '{16'h0000, 16'h0010, 16'h1234, 16'h8000, 16'hffff, 16'h00a5};
      s = $urandom_range(0, 7);
      q = '0;
      if ($urandom_range(0, 9) == 0) begin
         q.entry_index = 3'($urandom);
         q.opcode = 3'($urandom_range(0, 7));
         q.frame_length = 8'($urandom);
         q.address = 16'($urandom);
         q.value_bits = $urandom;
         q.entry_minimum = $urandom;
         q.entry_maximum = $urandom;
         q.capacity = 8'($urandom);
         return q;
      end
      q.opcode = ops[$urandom_range(0, 6)];
      q.frame_length = q.opcode == OP_DOWNLOAD ? LEN_DOWNLOAD :
                       q.opcode == OP_UPLOAD ? LEN_UPLOAD : 8'd1;
      if ($urandom_range(0, 11) == 0) q.frame_length = 8'($urandom_range(0, 9));
      q.capacity = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6));
      q.address = $urandom_range(0, 4) == 0 ? pool[$urandom_range(0, 5)] : book.slot_address[s];
      if ($urandom_range(0, 9) == 0) q.address = 16'($urandom);
      case ($urandom_range(0, 4))
         0: q.value_bits = book.slot_minimum[s];
         1: q.value_bits = book.slot_maximum[s];
         2: q.value_bits = pick_float();
         default: q.value_bits = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hc000_0000;
      endcase
      if (q.opcode == OP_LOAD) begin
         q.entry_index = 3'($urandom_range(0, 7));
         q.entry_minimum = pick_float();
         q.entry_maximum = pick_float();
         if ($urandom_range(0, 3) != 0 && book.fp_lt(q.entry_maximum, q.entry_minimum))
            {q.entry_minimum, q.entry_maximum} = {q.entry_maximum, q.entry_minimum};
         q.frame_length = 8'($urandom);
      end
      return q;
   endfunction

   initial begin
      logic [3:0] counts[6] = '{4'd8, 4'd1, 4'd5, 4'd8, 4'd3, 4'd1};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // not connected paths and frame checks
      send_request(make_request(OP_STATUS, 8'd1, 8'd1, 16'h0, 32'h0));
      send_request(make_request(OP_DOWNLOAD, LEN_DOWNLOAD, 8'd2, 16'h0, 32'h0));
      send_request(make_request(OP_UPLOAD, LEN_UPLOAD, 8'd255, 16'h0, 32'h0));
      send_request(make_request(OP_CONNECT, 8'd0, 8'd255, 16'h0, 32'h0));
      send_request(make_request(OP_CONNECT, 8'd9, 8'd2, 16'h0, 32'h0));
      send_request(make_request(OP_CONNECT, 8'd255, 8'd0, 16'hffff, 32'hffffffff));
      send_request(make_request(OP_UNKNOWN, 8'd5, 8'd1, 16'h0, 32'h0));
      send_request(make_request(3'd7, 8'd8, 8'd2, 16'h0, 32'h0));
      send_request(make_request(OP_CONNECT, 8'd2, 8'd0, 16'h0, 32'h0));
      send_request(make_request(OP_CONNECT, 8'd2, 8'd2, 16'h0, 32'h0));
      // fill every slot before any lookup can run
      for (int i = 0; i < 8; i++)
         send_request(make_load(3'(i), i == 7 ? 16'hffff : 16'(i * 16),
                                32'hc2c8_0000, 32'h42c8_0000, 32'h3f80_0000));
      send_request(make_load(3'd2, 16'h0abc, 32'h3f80_0000, 32'hbf80_0000, 32'h0));
      send_request(make_load(3'd3, 16'hffff, 32'h0, 32'h3f80_0000, 32'h0));
      send_request(make_load(3'd0, 16'h0000, 32'h7fc0_0000, 32'hffff_ffff, 32'h1234_5678));
      // connected paths
      send_request(make_request(OP_CONNECT, 8'd1, 8'd0, 16'h0, 32'h0));
      send_request(make_request(OP_STATUS, 8'd1, 8'd3, 16'h0, 32'h0));
      send_request(make_request(OP_UPLOAD, LEN_UPLOAD, 8'd4, 16'h0, 32'h0));
      send_request(make_request(OP_UPLOAD, LEN_UPLOAD, 8'd5, 16'h4444, 32'h0));
      send_request(make_request(OP_DOWNLOAD, LEN_DOWNLOAD, 8'd0, 16'h0, 32'h7fc0_0001));
      send_request(make_request(OP_UPLOAD, LEN_UPLOAD, 8'd5, 16'h0, 32'h0));
      send_request(make_request(OP_STATUS, 8'd1, 8'd255, 16'h0, 32'h0));
      drain();

      for (int p = 0; p < 6; p++) begin
         write_entry_count(p == 2 ? 4'($urandom_range(2, 7)) : counts[p]);
         for (int n = 0; n < 150; n++) begin
            if (p == 3 && n == 70) begin
               req_valid <= 1'b0;
               burst_left = 0;
               while (book.pending_replies.size() != 0) @(posedge clock);
            end
            send_request(random_request());
         end
         drain();
      end

      if (book.failures == 0) begin
         $display("PASS calibration_command_responder");
      end else begin
         $display("FAIL calibration_command_responder");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAIL calibration_command_responder");
      $finish;
   end

endmodule
`default_nettype wire

### calibration_command_responder.f
rtl/core/ccr_pkg.sv
rtl/core/ccr_front.sv
rtl/core/ccr_queue.sv
rtl/core/ccr_back.sv
rtl/core/calibration_command_responder.sv
dv/testbench.sv
